[hw/rtl/aafp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aafp_pkg
// Shared types, constants and helper functions for the ASCII attitude frame
// parser: status codes, default parameter values and the CRC-16 byte step.
// ----------------------------------------------------------------------------
package aafp_pkg;

    // Default parameter values.
    localparam int VALUE_WIDTH_DEF     = 32;
    localparam int FRACTION_DIGITS_DEF = 3;

    // Width of each angle field in the result.
    localparam int ANGLE_W  = 32;
    localparam int STATUS_W = 2;

    // Result data packing: status, pitch, yaw, roll, padded to whole bytes.
    localparam int RESULT_BITS = STATUS_W + 3 * ANGLE_W;
    localparam int M_TDATA_W   = ((RESULT_BITS + 7) / 8) * 8;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_FRAME_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CRC_BAD   = 2'd2;

    // CRC-16/MODBUS parameters.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Width of the largest power of ten that scaling needs (six fraction digits).
    localparam int POW10_W = 20;

    typedef logic [15:0] crc_t;

    // One byte of the reflected CRC-16 update, bit by bit.
    function automatic crc_t crc16_byte(input crc_t crc_in, input logic [7:0] data);
        crc_t c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // CRC state after the frame prefix "ARP" has been hashed.
    localparam crc_t CRC_AFTER_PREFIX =
        crc16_byte(crc16_byte(crc16_byte(CRC_INIT, 8'h41), 8'h52), 8'h50);

    // Powers of ten used to scale a number to its fixed point.
    function automatic logic [POW10_W-1:0] pow10(input logic [2:0] k);
        logic [POW10_W-1:0] p;
        case (k)
            3'd0:    p = 20'd1;
            3'd1:    p = 20'd10;
            3'd2:    p = 20'd100;
            3'd3:    p = 20'd1000;
            3'd4:    p = 20'd10000;
            3'd5:    p = 20'd100000;
            3'd6:    p = 20'd1000000;
            default: p = 20'd1;
        endcase
        return p;
    endfunction

endpackage

[hw/rtl/aafp_dec_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aafp_dec_unit
// Saturating decimal arithmetic for the number fields: the times-ten
// accumulate of one digit, and the final scaling to the fixed point.
// ----------------------------------------------------------------------------
module aafp_dec_unit #(
    parameter int VALUE_WIDTH     = aafp_pkg::VALUE_WIDTH_DEF,
    parameter int FRACTION_DIGITS = aafp_pkg::FRACTION_DIGITS_DEF,
    localparam int MAG_W = VALUE_WIDTH - 1,
    localparam int FCW   = (FRACTION_DIGITS > 0) ? $clog2(FRACTION_DIGITS + 1) : 1
) (
    input  logic [MAG_W-1:0] acc_in,     // Current magnitude.
    input  logic [3:0]       digit,      // Decimal digit to append.
    input  logic [FCW-1:0]   frac_cnt,   // Fraction digits taken so far.
    output logic [MAG_W-1:0] mac_out,    // acc_in * 10 + digit, saturated.
    output logic [MAG_W-1:0] scaled_out  // acc_in scaled to the fixed point, saturated.
);

    localparam int POW10_W = aafp_pkg::POW10_W;

    localparam logic [MAG_W-1:0] VMAX = '1;
    localparam logic [MAG_W-1:0] Q10  = MAG_W'(VMAX / 10);
    localparam logic [3:0]       R10  = 4'(VMAX % 10);

    // Largest magnitude that survives scaling by 10^k without saturating.
    localparam logic [MAG_W-1:0] LIM [0:6] = '{
        VMAX,
        MAG_W'(VMAX / 10),
        MAG_W'(VMAX / 100),
        MAG_W'(VMAX / 1000),
        MAG_W'(VMAX / 10000),
        MAG_W'(VMAX / 100000),
        MAG_W'(VMAX / 1000000)
    };

    logic [MAG_W-1:0]         mac_limit;
    logic [MAG_W+2:0]         mac_sum;
    logic [2:0]               scale_k;
    logic [MAG_W+POW10_W-1:0] scale_prod;

    // Times-ten accumulate: (max - d) / 10 is the overflow threshold.
    always_comb begin
        mac_limit = (digit <= R10) ? Q10 : (Q10 - 1'b1);
        mac_sum   = {acc_in, 3'b000} + {2'b00, acc_in, 1'b0} + (MAG_W + 3)'(digit);
        if (acc_in > mac_limit) begin
            mac_out = VMAX;
        end else begin
            mac_out = mac_sum[MAG_W-1:0];
        end
    end

    // Scale by the fraction digits still missing.
    always_comb begin
        scale_k    = 3'(FRACTION_DIGITS - int'(frac_cnt));
        scale_prod = (MAG_W + POW10_W)'(acc_in) *
                     (MAG_W + POW10_W)'(aafp_pkg::pow10(scale_k));
        if (acc_in > LIM[scale_k]) begin
            scaled_out = VMAX;
        end else begin
            scaled_out = scale_prod[MAG_W-1:0];
        end
    end

endmodule

[hw/rtl/ascii_attitude_frame_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_attitude_frame_parser
// Parses ARP<num>Y<num>R<num>C<hhhh> attitude lines from a serial byte
// stream, checks the CRC-16/MODBUS and reports one result per newline.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; the parse state is updated by a single
// pass of logic between the input register and the result register.
// A newline byte passes the input register, then its result is registered.
// Bytes other than newline produce no result; a held result stalls input.
// Reset (aresetn low, synchronous) empties both registers and returns the
// parser to searching for the frame prefix.
module ascii_attitude_frame_parser #(
    parameter int VALUE_WIDTH     = aafp_pkg::VALUE_WIDTH_DEF,
    parameter int FRACTION_DIGITS = aafp_pkg::FRACTION_DIGITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input byte stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] rx_byte
    // Result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [1:0] status, [33:2] pitch_milli, [65:34] yaw_milli, [97:66] roll_milli,
    // [103:98] zero
    output logic [aafp_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int MAG_W = VALUE_WIDTH - 1;
    localparam int FCW   = (FRACTION_DIGITS > 0) ? $clog2(FRACTION_DIGITS + 1) : 1;
    localparam int AW    = aafp_pkg::ANGLE_W;

    // Parse phases; the numeric phases are 1 + 4 * field + sub-step.
    localparam logic [4:0] PH_SEARCH = 5'd0;
    localparam logic [4:0] PH_NUM0   = 5'd1;
    localparam logic [4:0] PH_NUM_END = 5'd12;
    localparam logic [4:0] PH_HEX    = 5'd13;
    localparam logic [4:0] PH_TRAIL  = 5'd14;

    localparam logic [1:0] SUB_START = 2'd0;
    localparam logic [1:0] SUB_SIGN  = 2'd1;
    localparam logic [1:0] SUB_INT   = 2'd2;
    localparam logic [1:0] SUB_FRAC  = 2'd3;

    localparam logic [1:0] FIELD_PITCH = 2'd0;
    localparam logic [1:0] FIELD_YAW   = 2'd1;
    localparam logic [1:0] FIELD_ROLL  = 2'd2;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_PCT   = 8'h25;

    // Pipeline registers.
    logic                           in_valid_reg, in_valid_next;
    logic [7:0]                     in_byte_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [aafp_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;

    // Line parse state.
    logic [4:0]         phase_reg, phase_next;
    logic [1:0]         prog_reg, prog_next;
    aafp_pkg::crc_t     crc_reg, crc_next;
    logic [MAG_W-1:0]   acc_reg, acc_next;
    logic               neg_reg, neg_next;
    logic [FCW-1:0]     fcnt_reg, fcnt_next;
    logic [MAG_W-1:0]   pitch_mag_reg, pitch_mag_next;
    logic               pitch_neg_reg, pitch_neg_next;
    logic [MAG_W-1:0]   yaw_mag_reg, yaw_mag_next;
    logic               yaw_neg_reg, yaw_neg_next;
    logic [MAG_W-1:0]   roll_mag_reg, roll_mag_next;
    logic               roll_neg_reg, roll_neg_next;
    aafp_pkg::crc_t     rcrc_reg, rcrc_next;
    logic [2:0]         hcnt_reg, hcnt_next;
    logic               err_reg, err_next;

    logic               advance;
    logic [7:0]         b;
    logic [3:0]         num_idx;
    logic [1:0]         field;
    logic [1:0]         sub;
    logic [7:0]         term;
    logic               is_digit;
    logic               is_space;
    logic               hex_ok;
    logic [3:0]         hex_val;
    logic [7:0]         prefix_char;
    logic               framed;
    logic [1:0]         status;
    logic [MAG_W-1:0]   mac_mag;
    logic [MAG_W-1:0]   scaled_mag;

    // Magnitude and sign to the 32-bit two's complement result field.
    function automatic logic [AW-1:0] to_angle(input logic [MAG_W-1:0] mag,
                                               input logic neg);
        logic [MAG_W+AW:0] ext;
        logic [AW-1:0]     m;
        ext = {{(AW + 1){1'b0}}, mag};
        m   = ext[AW-1:0];
        return neg ? (~m + 1'b1) : m;
    endfunction

    aafp_dec_unit #(
        .VALUE_WIDTH     (VALUE_WIDTH),
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_dec (
        .acc_in     (acc_reg),
        .digit      (in_byte_reg[3:0]),
        .frac_cnt   (fcnt_reg),
        .mac_out    (mac_mag),
        .scaled_out (scaled_mag)
    );

    // Handshake: the byte stage moves whenever the result stage can take it.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Byte classification.
    always_comb begin
        b        = in_byte_reg;
        num_idx  = 4'(phase_reg - PH_NUM0);
        field    = num_idx[3:2];
        sub      = num_idx[1:0];
        is_digit = (b inside {[8'h30:8'h39]});
        is_space = (b inside {8'h20, [8'h09:8'h0D]});
        case (field)
            FIELD_PITCH: term = CH_Y;
            FIELD_YAW:   term = CH_R;
            default:     term = CH_C;
        endcase
        case (prog_reg)
            2'd0:    prefix_char = CH_A;
            2'd1:    prefix_char = CH_R;
            default: prefix_char = CH_P;
        endcase
        hex_ok  = 1'b1;
        hex_val = b[3:0];
        case (b) inside
            [8'h30:8'h39]: hex_val = b[3:0];
            [8'h41:8'h46],
            [8'h61:8'h66]: hex_val = 4'(b[2:0] + 4'd9);
            default:       hex_ok  = 1'b0;
        endcase
    end

    // End-of-line verdict.
    always_comb begin
        framed = !err_reg &&
                 (phase_reg == PH_TRAIL || (phase_reg == PH_HEX && hcnt_reg == 3'd4));
        if (!framed) begin
            status = aafp_pkg::ST_MALFORMED;
        end else if (crc_reg != rcrc_reg) begin
            status = aafp_pkg::ST_CRC_BAD;
        end else begin
            status = aafp_pkg::ST_FRAME_OK;
        end
    end

    // Parse state update, one byte per advancing cycle.
    always_comb begin
        phase_next     = phase_reg;
        prog_next      = prog_reg;
        crc_next       = crc_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        fcnt_next      = fcnt_reg;
        pitch_mag_next = pitch_mag_reg;
        pitch_neg_next = pitch_neg_reg;
        yaw_mag_next   = yaw_mag_reg;
        yaw_neg_next   = yaw_neg_reg;
        roll_mag_next  = roll_mag_reg;
        roll_neg_next  = roll_neg_reg;
        rcrc_next      = rcrc_reg;
        hcnt_next      = hcnt_reg;
        err_next       = err_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        in_valid_next  = in_valid_reg;

        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        if (advance) begin
            out_valid_next = 1'b0;
        end

        if (in_valid_reg && advance) begin
            if (b == CH_LF) begin
                // Emit the line result and start over.
                out_valid_next = 1'b1;
                out_data_next  = '0;
                out_data_next[1:0] = status;
                if (status == aafp_pkg::ST_FRAME_OK) begin
                    out_data_next[2 +: AW]          = to_angle(pitch_mag_reg, pitch_neg_reg);
                    out_data_next[2 + AW +: AW]     = to_angle(yaw_mag_reg, yaw_neg_reg);
                    out_data_next[2 + 2 * AW +: AW] = to_angle(roll_mag_reg, roll_neg_reg);
                end
                phase_next     = PH_SEARCH;
                prog_next      = '0;
                crc_next       = aafp_pkg::CRC_INIT;
                acc_next       = '0;
                neg_next       = 1'b0;
                fcnt_next      = '0;
                pitch_mag_next = '0;
                pitch_neg_next = 1'b0;
                yaw_mag_next   = '0;
                yaw_neg_next   = 1'b0;
                roll_mag_next  = '0;
                roll_neg_next  = 1'b0;
                rcrc_next      = '0;
                hcnt_next      = '0;
                err_next       = 1'b0;
            end else if (!err_reg) begin
                case (phase_reg) inside
                    PH_SEARCH: begin
                        // Look for the "ARP" prefix.
                        if (b == prefix_char) begin
                            prog_next = prog_reg + 1'b1;
                        end else begin
                            prog_next = (b == CH_A) ? 2'd1 : 2'd0;
                        end
                        if (prog_reg == 2'd2 && b == CH_P) begin
                            prog_next  = '0;
                            crc_next   = aafp_pkg::CRC_AFTER_PREFIX;
                            phase_next = PH_NUM0;
                        end
                    end
                    [PH_NUM0:PH_NUM_END]: begin
                        // The CRC covers everything before the checksum marker.
                        if (b != CH_C || field != FIELD_ROLL) begin
                            crc_next = aafp_pkg::crc16_byte(crc_reg, b);
                        end
                        if (sub == SUB_START && (b == CH_PLUS || b == CH_MINUS)) begin
                            neg_next   = (b == CH_MINUS);
                            phase_next = 5'(PH_NUM0 + {1'b0, field, SUB_SIGN});
                        end else if (is_digit && sub != SUB_FRAC) begin
                            acc_next   = mac_mag;
                            phase_next = 5'(PH_NUM0 + {1'b0, field, SUB_INT});
                        end else if (is_digit) begin
                            if (fcnt_reg < FCW'(FRACTION_DIGITS)) begin
                                acc_next  = mac_mag;
                                fcnt_next = fcnt_reg + 1'b1;
                            end
                        end else if (sub == SUB_INT && b == CH_POINT) begin
                            phase_next = 5'(PH_NUM0 + {1'b0, field, SUB_FRAC});
                        end else if ((sub == SUB_INT || sub == SUB_FRAC) && b == term) begin
                            // Number complete: scale it and store it by field.
                            acc_next  = '0;
                            fcnt_next = '0;
                            neg_next  = 1'b0;
                            case (field)
                                FIELD_PITCH: begin
                                    pitch_mag_next = scaled_mag;
                                    pitch_neg_next = neg_reg;
                                    phase_next     = 5'(PH_NUM0 + 5'd4);
                                end
                                FIELD_YAW: begin
                                    yaw_mag_next = scaled_mag;
                                    yaw_neg_next = neg_reg;
                                    phase_next   = 5'(PH_NUM0 + 5'd8);
                                end
                                default: begin
                                    roll_mag_next = scaled_mag;
                                    roll_neg_next = neg_reg;
                                    phase_next    = PH_HEX;
                                end
                            endcase
                        end else begin
                            err_next = 1'b1;
                        end
                    end
                    PH_HEX: begin
                        // Four hex digits, then '%' or whitespace.
                        if (hex_ok && hcnt_reg < 3'd4) begin
                            rcrc_next = {rcrc_reg[11:0], hex_val};
                            hcnt_next = hcnt_reg + 1'b1;
                        end else if (hcnt_reg == 3'd4 && (b == CH_PCT || is_space)) begin
                            phase_next = PH_TRAIL;
                        end else begin
                            err_next = 1'b1;
                        end
                    end
                    default: begin
                        // Trailing text must be whitespace.
                        if (!is_space) begin
                            err_next = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // Control and parse state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_SEARCH;
            prog_reg      <= '0;
            crc_reg       <= aafp_pkg::CRC_INIT;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            fcnt_reg      <= '0;
            pitch_mag_reg <= '0;
            pitch_neg_reg <= 1'b0;
            yaw_mag_reg   <= '0;
            yaw_neg_reg   <= 1'b0;
            roll_mag_reg  <= '0;
            roll_neg_reg  <= 1'b0;
            rcrc_reg      <= '0;
            hcnt_reg      <= '0;
            err_reg       <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            prog_reg      <= prog_next;
            crc_reg       <= crc_next;
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            fcnt_reg      <= fcnt_next;
            pitch_mag_reg <= pitch_mag_next;
            pitch_neg_reg <= pitch_neg_next;
            yaw_mag_reg   <= yaw_mag_next;
            yaw_neg_reg   <= yaw_neg_next;
            roll_mag_reg  <= roll_mag_next;
            roll_neg_reg  <= roll_neg_next;
            rcrc_reg      <= rcrc_next;
            hcnt_reg      <= hcnt_next;
            err_reg       <= err_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        out_data_reg <= out_data_next;
    end

endmodule

[sim/attitude_frame_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attitude_frame_checker
// Watches both streams of the attitude frame parser, predicts the result of
// every newline-ended line from the bytes it sees accepted, and compares each
// accepted result against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module attitude_frame_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] rx_byte
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // [1:0] status, [33:2] pitch_milli, [65:34] yaw_milli, [97:66] roll_milli,
    // [103:98] zero
    input  logic [aafp_pkg::M_TDATA_W-1:0] m_tdata,
    output int                             mismatch_count = 0,
    output int                             frames_waiting = 0
);

    // Largest magnitude an angle may take, and the number of kept decimals.
    localparam logic [63:0] MAG_LIMIT   = (64'd1 << (aafp_pkg::VALUE_WIDTH_DEF - 1)) - 64'd1;
    localparam int          FRAC_PLACES = aafp_pkg::FRACTION_DIGITS_DEF;

    // Characters that delimit a frame.
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_A       = 8'h41;
    localparam logic [7:0] CH_R       = 8'h52;
    localparam logic [7:0] CH_P       = 8'h50;
    localparam logic [7:0] CH_Y       = 8'h59;
    localparam logic [7:0] CH_C       = 8'h43;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_PERCENT = 8'h25;

    typedef enum logic [1:0] {SCAN_PREFIX, SCAN_NUMBER, SCAN_HEX, SCAN_TRAIL} scan_phase_t;
    typedef enum logic [1:0] {NUM_START, NUM_SIGN, NUM_INT, NUM_FRAC} num_part_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] pitch;
        logic [31:0] yaw;
        logic [31:0] roll;
    } attitude_t;

    attitude_t expected_frames[$];

    // Parser state as the predictor tracks it.
    scan_phase_t phase       = SCAN_PREFIX;
    num_part_t   part        = NUM_START;
    logic [1:0]  field       = 2'd0;
    logic [1:0]  prefix_seen = 2'd0;
    logic [15:0] crc_run     = aafp_pkg::CRC_INIT;
    logic [63:0] mag         = 64'd0;
    logic        negative    = 1'b0;
    int          frac_seen   = 0;
    logic [31:0] pitch_keep  = 32'd0;
    logic [31:0] yaw_keep    = 32'd0;
    logic [31:0] roll_keep   = 32'd0;
    logic [15:0] crc_rx      = 16'd0;
    int          hex_seen    = 0;
    logic        broken      = 1'b0;
    int          fail_tally  = 0;

    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            x = x[0] ? ((x >> 1) ^ aafp_pkg::CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

    // Decimal shift-in that sticks at the limit instead of wrapping.
    function automatic logic [63:0] times_ten_plus(input logic [63:0] acc, input logic [3:0] d);
        if (acc > (MAG_LIMIT - {60'd0, d}) / 64'd10) begin
            return MAG_LIMIT;
        end
        return acc * 64'd10 + {60'd0, d};
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic int hex_nibble(input logic [7:0] b);
        if (b >= "0" && b <= "9") begin
            return int'(b - 8'h30);
        end
        if (b >= "A" && b <= "F") begin
            return int'(b - 8'h41) + 10;
        end
        if (b >= "a" && b <= "f") begin
            return int'(b - 8'h61) + 10;
        end
        return -1;
    endfunction

    task automatic clear_scan();
        phase       = SCAN_PREFIX;
        part        = NUM_START;
        field       = 2'd0;
        prefix_seen = 2'd0;
        crc_run     = aafp_pkg::CRC_INIT;
        mag         = 64'd0;
        negative    = 1'b0;
        frac_seen   = 0;
        pitch_keep  = 32'd0;
        yaw_keep    = 32'd0;
        roll_keep   = 32'd0;
        crc_rx      = 16'd0;
        hex_seen    = 0;
        broken      = 1'b0;
    endtask

    // Pads the number out to the fixed number of decimals and applies the sign.
    task automatic close_number(output logic [31:0] v);
        logic [63:0] m;
        m = mag;
        for (int i = frac_seen; i < FRAC_PLACES; i++) begin
            m = times_ten_plus(m, 4'd0);
        end
        if (negative) begin
            m = 64'd0 - m;
        end
        mag       = 64'd0;
        frac_seen = 0;
        negative  = 1'b0;
        v         = m[31:0];
    endtask

    task automatic number_byte(input logic [7:0] b);
        logic [7:0]  term;
        logic        is_digit;
        logic [31:0] v;
        term     = (field == 2'd0) ? CH_Y : (field == 2'd1) ? CH_R : CH_C;
        is_digit = (b >= "0" && b <= "9");
        // The 'C' that ends the roll value is not part of the checksum.
        if (!(b == CH_C && field == 2'd2)) begin
            crc_run = crc_step(crc_run, b);
        end
        if (part == NUM_START && (b == CH_PLUS || b == CH_MINUS)) begin
            negative = (b == CH_MINUS);
            part     = NUM_SIGN;
        end else if (is_digit && part != NUM_FRAC) begin
            mag  = times_ten_plus(mag, b[3:0]);
            part = NUM_INT;
        end else if (is_digit) begin
            // Decimals past the kept ones are dropped.
            if (frac_seen < FRAC_PLACES) begin
                mag = times_ten_plus(mag, b[3:0]);
                frac_seen++;
            end
        end else if (part == NUM_INT && b == CH_DOT) begin
            part = NUM_FRAC;
        end else if ((part == NUM_INT || part == NUM_FRAC) && b == term) begin
            close_number(v);
            part = NUM_START;
            if (field == 2'd0) begin
                pitch_keep = v;
                field      = 2'd1;
            end else if (field == 2'd1) begin
                yaw_keep = v;
                field    = 2'd2;
            end else begin
                roll_keep = v;
                phase     = SCAN_HEX;
            end
        end else begin
            broken = 1'b1;
        end
    endtask

    task automatic parse_byte(input logic [7:0] b);
        attitude_t  r;
        int         h;
        logic       framed;
        logic [7:0] want;
        if (b == CH_NEWLINE) begin
            // Every newline closes the line with one result.
            framed = !broken && (phase == SCAN_TRAIL || (phase == SCAN_HEX && hex_seen == 4));
            r      = '0;
            r.status = aafp_pkg::ST_MALFORMED;
            if (framed) begin
                if (crc_run != crc_rx) begin
                    r.status = aafp_pkg::ST_CRC_BAD;
                end else begin
                    r.status = aafp_pkg::ST_FRAME_OK;
                    r.pitch  = pitch_keep;
                    r.yaw    = yaw_keep;
                    r.roll   = roll_keep;
                end
            end
            expected_frames.insert(expected_frames.size(), r);
            clear_scan();
        end else if (!broken) begin
            case (phase)
                SCAN_PREFIX: begin
                    want = (prefix_seen == 2'd0) ? CH_A : (prefix_seen == 2'd1) ? CH_R : CH_P;
                    if (b == want) begin
                        prefix_seen = prefix_seen + 2'd1;
                    end else begin
                        prefix_seen = (b == CH_A) ? 2'd1 : 2'd0;
                    end
                    if (prefix_seen == 2'd3) begin
                        prefix_seen = 2'd0;
                        crc_run     = crc_step(crc_step(crc_step(aafp_pkg::CRC_INIT, CH_A),
                                                        CH_R), CH_P);
                        phase       = SCAN_NUMBER;
                        field       = 2'd0;
                        part        = NUM_START;
                    end
                end
                SCAN_NUMBER: begin
                    number_byte(b);
                end
                SCAN_HEX: begin
                    h = hex_nibble(b);
                    if (h >= 0 && hex_seen < 4) begin
                        crc_rx = {crc_rx[11:0], 4'(h)};
                        hex_seen++;
                    end else if (hex_seen == 4 && (b == CH_PERCENT || is_blank(b))) begin
                        phase = SCAN_TRAIL;
                    end else begin
                        broken = 1'b1;
                    end
                end
                default: begin
                    if (!is_blank(b)) begin
                        broken = 1'b1;
                    end
                end
            endcase
        end
    endtask

    task automatic compare_result(input logic [aafp_pkg::M_TDATA_W-1:0] got);
        attitude_t want;
        if (expected_frames.size() == 0) begin
            $display("%0t: result with no line pending, expected none, actual %h", $time, got);
            fail_tally++;
        end else begin
            want = expected_frames.pop_front();
            if (got[1:0] != want.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, got[1:0]);
                fail_tally++;
            end
            if (got[33:2] != want.pitch) begin
                $display("%0t: pitch mismatch, expected %0d, actual %0d",
                         $time, $signed(want.pitch), $signed(got[33:2]));
                fail_tally++;
            end
            if (got[65:34] != want.yaw) begin
                $display("%0t: yaw mismatch, expected %0d, actual %0d",
                         $time, $signed(want.yaw), $signed(got[65:34]));
                fail_tally++;
            end
            if (got[97:66] != want.roll) begin
                $display("%0t: roll mismatch, expected %0d, actual %0d",
                         $time, $signed(want.roll), $signed(got[97:66]));
                fail_tally++;
            end
            if (got[aafp_pkg::M_TDATA_W-1:98] != '0) begin
                $display("%0t: padding mismatch, expected 0, actual %h",
                         $time, got[aafp_pkg::M_TDATA_W-1:98]);
                fail_tally++;
            end
        end
    endtask

    // Predict on every accepted byte request, compare on every accepted result.
    always @(posedge aclk) begin : monitor
        if (!aresetn) begin
            clear_scan();
            expected_frames.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                compare_result(m_tdata);
            end
        end
        frames_waiting <= expected_frames.size();
        mismatch_count <= fail_tally;
    end

endmodule

[sim/tb_ascii_attitude_frame_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ascii_attitude_frame_parser
// Feeds the attitude frame parser with directed lines and then with random
// frames, broken frames and noise, with random pauses on both streams, and
// reports the verdict of the checker once every result has arrived.
// ----------------------------------------------------------------------------
module tb_ascii_attitude_frame_parser;

    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_BYTES = 1000;
    localparam int PHASES       = 5;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata  = 8'h00;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [aafp_pkg::M_TDATA_W-1:0] m_tdata;

    int   mismatch_count;
    int   frames_waiting;
    logic idle_mode    = 1'b1;
    int   sink_hold    = 0;
    int   quiet_cycles = 0;
    int   bytes_sent   = 0;

    // Bytes of the line being built, newline excluded.
    logic [7:0] line_q[$];

    ascii_attitude_frame_parser uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    attitude_frame_checker frame_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .frames_waiting (frames_waiting)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Pause length: mostly short, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(30, 60);
    endfunction

    function automatic logic [7:0] blank_byte();
        case ($urandom_range(0, 4))
            0:       return 8'h20;
            1:       return 8'h09;
            2:       return 8'h0B;
            3:       return 8'h0C;
            default: return 8'h0D;
        endcase
    endfunction

    // Result side stalls at random while idling is on.
    always @(posedge aclk) begin : sink_pace
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_hold <= 0;
        end else if (!idle_mode) begin
            m_tready <= 1'b1;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_tready  <= 1'b0;
        end else if ($urandom_range(0, 99) < 70) begin
            m_tready <= 1'b1;
        end else begin
            m_tready  <= 1'b0;
            sink_hold <= gap_len() - 1;
        end
    end

    // Ends the run if neither stream moves for too long.
    always @(posedge aclk) begin : stall_watch
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One byte request, held until it is accepted.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (idle_mode && $urandom_range(0, 99) < 45) ? gap_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    // Adds one byte at the end of the line being built.
    task automatic append_byte(input logic [7:0] v);
        line_q.insert(line_q.size(), v);
    endtask

    task automatic send_line();
        append_byte(8'h0A);
        foreach (line_q[i]) begin
            send_byte(line_q[i]);
        end
        line_q.delete();
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            append_byte(s[i]);
        end
    endtask

    // Signed decimal, mostly short, sometimes long enough to saturate.
    task automatic push_number();
        int sign_pick;
        int digits;
        sign_pick = $urandom_range(0, 2);
        if (sign_pick == 1) begin
            push_text("+");
        end else if (sign_pick == 2) begin
            push_text("-");
        end
        digits = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 4);
        repeat (digits) append_byte(8'h30 + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 1) == 1) begin
            push_text(".");
            repeat ($urandom_range(0, 5)) append_byte(8'h30 + 8'($urandom_range(0, 9)));
        end
    endtask

    // Appends 'C' and the checksum of the frame so far XORed with flip, each digit in random case.
    task automatic close_frame(input int arp_at, input logic [15:0] flip);
        logic [15:0] crc;
        logic [3:0]  nib;
        string       upper;
        string       lower;
        upper = "0123456789ABCDEF";
        lower = "0123456789abcdef";
        crc   = aafp_pkg::CRC_INIT;
        for (int i = arp_at; i < line_q.size(); i++) begin
            crc = aafp_pkg::crc16_byte(crc, line_q[i]);
        end
        crc = crc ^ flip;
        push_text("C");
        for (int n = 3; n >= 0; n--) begin
            nib = crc[4*n +: 4];
            append_byte(($urandom_range(0, 1) == 1) ? lower[nib] : upper[nib]);
        end
    endtask

    task automatic directed_frame(input string p, input string y, input string r,
                                  input logic [15:0] flip, input string tail);
        int arp_at;
        arp_at = line_q.size();
        push_text({"ARP", p, "Y", y, "R", r});
        close_frame(arp_at, flip);
        push_text(tail);
        send_line();
    endtask

    // Well-formed frame with random content, now and then damaged on purpose.
    task automatic random_frame();
        int    arp_at;
        int    pick;
        int    pos;
        string junk;
        string marks;
        junk  = "ARPx 7Y";
        marks = "ARPYC.+-%0 x";
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) append_byte(junk[$urandom_range(0, junk.len() - 1)]);
        end
        arp_at = line_q.size();
        push_text("ARP");
        push_number();
        push_text("Y");
        push_number();
        push_text("R");
        push_number();
        pick = $urandom_range(0, 99);
        close_frame(arp_at, (pick >= 60 && pick < 70) ? 16'($urandom_range(1, 65535)) : 16'h0000);
        if (pick >= 70 && pick < 85) begin
            // Replace, insert or drop one byte inside the frame.
            pos = $urandom_range(arp_at, line_q.size() - 1);
            case ($urandom_range(0, 2))
                0:       line_q[pos] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                       : marks[$urandom_range(0, marks.len() - 1)];
                1:       line_q.insert(pos, marks[$urandom_range(0, marks.len() - 1)]);
                default: line_q.delete(pos);
            endcase
        end else if (pick >= 85 && pick < 90) begin
            // Fifth hex digit.
            push_text("a");
        end else if (pick >= 90 && pick < 95) begin
            // Whitespace ahead of the percent sign.
            append_byte(blank_byte());
            push_text("%");
        end
        if ($urandom_range(0, 1) == 1) begin
            push_text("%");
        end
        repeat ($urandom_range(0, 3)) append_byte(blank_byte());
        send_line();
    endtask

    // Stops sending and waits until every predicted result has come out.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (frames_waiting != 0);
    endtask

    initial begin : stimulus
        int    base;
        int    pick;
        string soup;
        soup = "0123456789+-.YRCaF% ";

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed lines: empty, blank, no prefix and byte extremes first.
        send_line();
        push_text(" ");
        append_byte(8'h09);
        append_byte(8'h0D);
        append_byte(8'h0B);
        append_byte(8'h0C);
        send_line();
        push_text("AR ARX APR no frame");
        send_line();
        append_byte(8'h00);
        append_byte(8'hFF);
        append_byte(8'h80);
        append_byte(8'h7F);
        send_line();
        directed_frame("0", "0", "0", 16'h0000, "");
        // Extra decimals and negative zero.
        directed_frame("+123.4567", "-0", "-0.0001", 16'h0000, "%  ");
        // Saturation on both signs, and the limit hit exactly.
        directed_frame("99999999999", "-99999999999", "2147483.647", 16'h0000, " ");
        directed_frame("-2147483.648", "2147484", "-0.999", 16'h0000, "%");
        // Checksum off by one bit.
        directed_frame("1.", "-2.5", "+3", 16'h0001, "");
        // Fifth hex digit, then blank ahead of the percent sign.
        directed_frame("4", "5", "6", 16'h0000, "0");
        directed_frame("7", "8", "9", 16'h0000, " %");
        // Text after the trailing blanks.
        directed_frame("12.", "3.000", "-45.6", 16'h0000, "% x");
        push_text("ARP--1Y2R3C0000");
        send_line();
        // A second prefix after a broken first one is not tried.
        push_text("ARPxARP1Y2R3C0000");
        send_line();
        drain_results();

        // Random lines in phases, with and without idling.
        base = bytes_sent;
        for (int ph = 0; ph < PHASES; ph++) begin
            idle_mode <= (ph != 0 && ph != 3);
            while (bytes_sent < base + (ph + 1) * (RANDOM_BYTES / PHASES)) begin
                pick = $urandom_range(0, 99);
                if (pick < 68) begin
                    random_frame();
                end else if (pick < 78) begin
                    repeat ($urandom_range(1, 16)) append_byte(8'($urandom_range(0, 255)));
                    send_line();
                end else if (pick < 90) begin
                    push_text("ARP");
                    repeat ($urandom_range(3, 18)) begin
                        append_byte(soup[$urandom_range(0, soup.len() - 1)]);
                    end
                    send_line();
                end else begin
                    repeat ($urandom_range(0, 4)) append_byte(blank_byte());
                    send_line();
                end
            end
            drain_results();
        end

        // Let the pipeline settle before the verdict.
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
